// ===== hdl/q12_vector_normalize_unit_macros.svh =====
// Assertion macros shared by the vector normalise unit.
// Each macro takes a label, the clock, the active-low reset, a condition,
// a consequence and a message string.
`ifndef Q12_VECTOR_NORMALIZE_UNIT_MACROS_SVH
`define Q12_VECTOR_NORMALIZE_UNIT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define Q12VN_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the condition.
`define Q12VN_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/q12vn_pkg.sv =====
package q12vn_pkg;

  localparam int IN_W   = 31;
  localparam int OUT_W  = 14;
  localparam int SQ_W   = 2 * IN_W;
  localparam int REM_W  = IN_W + 1;
  localparam int QUO_W  = 13;
  localparam int CNT_W  = 5;
  localparam int SEL_W  = 2;

  localparam logic signed [OUT_W-1:0] Q12_ONE = 14'sd4096;

  // Sequencer step limits.
  localparam logic [CNT_W-1:0] SQ_LAST   = 5'd3;
  localparam logic [CNT_W-1:0] ROOT_LAST = 5'd30;
  localparam logic [CNT_W-1:0] DIV_INIT  = 5'd0;
  localparam logic [CNT_W-1:0] DIV_LAST  = 5'd14;
  localparam logic [SEL_W-1:0] SEL_X     = 2'd0;
  localparam logic [SEL_W-1:0] SEL_Y     = 2'd1;
  localparam logic [SEL_W-1:0] SEL_Z     = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SQUARE = 5'b00010,
    ST_ROOT   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_WRITE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic             load;
    logic             mul_en;
    logic             acc_en;
    logic             root_step;
    logic             div_init;
    logic             div_step;
    logic             div_store;
    logic             out_load;
    logic [SEL_W-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic zero;
  } status_t;

endpackage

// ===== hdl/q12vn_in_if.sv =====
interface q12vn_in_if import q12vn_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] vec_x;
  logic signed [IN_W-1:0] vec_y;
  logic signed [IN_W-1:0] vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// ===== hdl/q12vn_out_if.sv =====
interface q12vn_out_if import q12vn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] unit_x;
  logic signed [OUT_W-1:0] unit_y;
  logic signed [OUT_W-1:0] unit_z;

  modport source (output valid, output unit_x, output unit_y, output unit_z, input ready);
  modport sink (input valid, input unit_x, input unit_y, input unit_z, output ready);
endinterface

// ===== hdl/q12vn_datapath.sv =====
module q12vn_datapath import q12vn_pkg::*; (
  input  logic                    clk,
  input  cmd_t                    cmd,
  input  logic signed [IN_W-1:0]  vec_x,
  input  logic signed [IN_W-1:0]  vec_y,
  input  logic signed [IN_W-1:0]  vec_z,
  output status_t                 status,
  output logic signed [OUT_W-1:0] unit_x,
  output logic signed [OUT_W-1:0] unit_y,
  output logic signed [OUT_W-1:0] unit_z
);

  logic [IN_W-1:0]         mag_r [3];
  logic [2:0]              neg_r;
  logic                    zero_r;
  logic [SQ_W-1:0]         prod_r;
  logic [SQ_W-1:0]         sum_r;
  logic [REM_W-1:0]        rem_r;
  logic [IN_W-1:0]         root_r;
  logic [REM_W-1:0]        drem_r;
  logic [QUO_W-1:0]        quo_r;
  logic signed [OUT_W-1:0] unit_r [3];
  logic signed [OUT_W-1:0] ox_r, oy_r, oz_r;

  logic [IN_W-1:0]    mag_sel;
  logic               neg_sel;
  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic [REM_W+1:0]   rem_diff;
  logic               root_ge;
  logic [REM_W-1:0]   rem_nxt;
  logic               div_ge;
  logic [REM_W-1:0]   div_diff;
  logic [REM_W-1:0]   div_keep;
  logic [OUT_W-1:0]   quo_ext;
  logic signed [OUT_W-1:0] quo_signed;

  function automatic logic [IN_W-1:0] mag_of(input logic signed [IN_W-1:0] v);
    mag_of = v[IN_W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    case (cmd.sel)
      SEL_X: begin
        mag_sel = mag_r[0];
        neg_sel = neg_r[0];
      end
      SEL_Y: begin
        mag_sel = mag_r[1];
        neg_sel = neg_r[1];
      end
      SEL_Z: begin
        mag_sel = mag_r[2];
        neg_sel = neg_r[2];
      end
      default: begin
        mag_sel = '0;
        neg_sel = 1'b0;
      end
    endcase
  end

  // One bit of the integer square root per step, from two bits of the sum.
  assign rem_sh   = {rem_r, sum_r[SQ_W-1 -: 2]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign root_ge  = (rem_sh >= trial);
  assign rem_diff = rem_sh - trial;
  assign rem_nxt  = root_ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];

  // One quotient bit per step; the remainder kept after each step stays below the length.
  assign div_ge   = (drem_r >= {1'b0, root_r});
  assign div_diff = drem_r - {1'b0, root_r};
  assign div_keep = div_ge ? div_diff : drem_r;

  assign quo_ext    = {1'b0, quo_r};
  assign quo_signed = neg_sel ? $signed(-quo_ext) : $signed(quo_ext);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r[0] <= mag_of(vec_x);
      mag_r[1] <= mag_of(vec_y);
      mag_r[2] <= mag_of(vec_z);
      neg_r    <= {vec_z[IN_W-1], vec_y[IN_W-1], vec_x[IN_W-1]};
      zero_r   <= (vec_x == '0) && (vec_y == '0) && (vec_z == '0);
      sum_r    <= '0;
      rem_r    <= '0;
      root_r   <= '0;
    end else if (cmd.acc_en) begin
      sum_r <= sum_r + prod_r;
    end else if (cmd.root_step) begin
      sum_r  <= {sum_r[SQ_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[IN_W-2:0], root_ge};
    end

    if (cmd.mul_en) begin
      prod_r <= SQ_W'(mag_sel) * SQ_W'(mag_sel);
    end

    if (cmd.div_init) begin
      drem_r <= {1'b0, mag_sel};
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      drem_r <= {div_keep[REM_W-2:0], 1'b0};
      quo_r  <= {quo_r[QUO_W-2:0], div_ge};
    end

    if (cmd.div_store) begin
      case (cmd.sel)
        SEL_X:   unit_r[0] <= quo_signed;
        SEL_Y:   unit_r[1] <= quo_signed;
        SEL_Z:   unit_r[2] <= quo_signed;
        default: unit_r[0] <= unit_r[0];
      endcase
    end

    if (cmd.out_load) begin
      if (zero_r) begin
        ox_r <= Q12_ONE;
        oy_r <= '0;
        oz_r <= '0;
      end else begin
        ox_r <= unit_r[0];
        oy_r <= unit_r[1];
        oz_r <= unit_r[2];
      end
    end
  end

  assign status.zero = zero_r;
  assign unit_x = ox_r;
  assign unit_y = oy_r;
  assign unit_z = oz_r;

endmodule

// ===== hdl/q12vn_ctrl.sv =====
`include "q12_vector_normalize_unit_macros.svh"

module q12vn_ctrl import q12vn_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SEL_W-1:0] sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.sel   = sel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.sel    = cnt_r[SEL_W-1:0];
        cmd.mul_en = (cnt_r != SQ_LAST);
        cmd.acc_en = (cnt_r != '0);
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = status.zero ? ST_WRITE : ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == ROOT_LAST) begin
          cnt_nxt   = '0;
          sel_nxt   = SEL_X;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_init  = (cnt_r == DIV_INIT);
        cmd.div_step  = (cnt_r != DIV_INIT) && (cnt_r != DIV_LAST);
        cmd.div_store = (cnt_r == DIV_LAST);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt = '0;
          if (sel_r == SEL_Z) begin
            state_nxt = ST_WRITE;
          end else begin
            sel_nxt = sel_r + 1'b1;
          end
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sel_r       <= SEL_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `Q12VN_ASSERT_NEXT(a_busy_after_load, clk, rst_n, cmd.load, !in_ready, "input taken while busy")
  `Q12VN_ASSERT_NOW(a_no_divide_on_zero, clk, rst_n, $rose(state_r == ST_DIVIDE), !status.zero, "division entered for a zero vector")
  `Q12VN_ASSERT_NOW(a_out_load_free, clk, rst_n, cmd.out_load, out_free, "result register overwritten before transfer")
  `Q12VN_ASSERT_NOW(a_root_count, clk, rst_n, state_r == ST_ROOT, cnt_r <= ROOT_LAST, "root step count overrun")

endmodule

// ===== hdl/q12_vector_normalize_unit.sv =====
// Q12 vector normalise unit. Each transfer on in_if carries one signed 31-bit
// three-component vector; exactly one transfer on out_if follows, carrying the
// vector scaled to unit length in Q12 (4096 is one), each component truncated
// toward zero and never beyond 4096 in magnitude. The length is the exact
// floor of the square root of the sum of squares. An all-zero vector yields
// (4096, 0, 0). The unit works on one vector at a time: after a transfer in,
// it forms the sum of squares on one shared 31x31 multiplier, takes the
// square root one root bit per step, runs three 13-bit divisions on one
// shared shift-subtract divider, then loads the result register once that
// register is free. A zero vector skips the root and the divisions, and a
// new vector is taken only once the unit is idle again. The result register
// decouples the two sides: the next vector may be accepted while the
// previous result still waits for its transfer.
`include "q12_vector_normalize_unit_macros.svh"

module q12_vector_normalize_unit import q12vn_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  q12vn_in_if.sink   in_if,
  q12vn_out_if.source out_if
);

  // Command and status between the sequencer and the datapath.
  cmd_t    cmd;
  status_t status;

  // The sequencer owns the handshakes and the step counters.
  q12vn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the operands, the root, the divider and the result.
  q12vn_datapath u_datapath (
    .clk    (clk),
    .cmd    (cmd),
    .vec_x  (in_if.vec_x),
    .vec_y  (in_if.vec_y),
    .vec_z  (in_if.vec_z),
    .status (status),
    .unit_x (out_if.unit_x),
    .unit_y (out_if.unit_y),
    .unit_z (out_if.unit_z)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the Q12 vector normalise unit.
//
// A table of directed vectors is sent first: the zero vector, unit steps on
// x with both signs and on y and z with one sign each, the extreme components
// -2^30 and 2^30-1, and a few short vectors with exact and inexact lengths.
// Rows whose answer is obvious carry it typed in; the rest, and all of the
// random vectors that follow, are checked against a bit-exact predictor kept
// in this file. Both sides of the unit see random gaps and stalls, with calm
// stretches in between.
module tb_top import q12vn_pkg::*; ();

  // Number of random vectors after the directed table.
  localparam int unsigned N_RANDOM = 800;
  // Cycles without any transfer before the run is declared hung. The
  // slowest honest gap is one long sender pause, a full pass through the
  // unit and the longest receiver stall.
  localparam int unsigned IDLE_LIMIT = 4000;
  // Cycles allowed after the last result before the verdict.
  localparam int unsigned DRAIN_CYCLES = 100;

  localparam logic signed [IN_W-1:0] V_MIN = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic signed [IN_W-1:0] V_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] Q12_NEG_ONE = -Q12_ONE;
  localparam logic signed [OUT_W-1:0] Q12_ZERO = '0;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } unit_vec_t;

  // One directed row: the vector, and where the answer is obvious, the
  // answer itself with typed set.
  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
    logic                   typed;
    unit_vec_t              want;
  } stim_row_t;

  localparam unit_vec_t UNIT_PX   = '{Q12_ONE, Q12_ZERO, Q12_ZERO};
  localparam unit_vec_t UNIT_NX   = '{Q12_NEG_ONE, Q12_ZERO, Q12_ZERO};
  localparam unit_vec_t UNIT_PY   = '{Q12_ZERO, Q12_ONE, Q12_ZERO};
  localparam unit_vec_t UNIT_NY   = '{Q12_ZERO, Q12_NEG_ONE, Q12_ZERO};
  localparam unit_vec_t UNIT_PZ   = '{Q12_ZERO, Q12_ZERO, Q12_ONE};
  localparam unit_vec_t UNIT_NZ   = '{Q12_ZERO, Q12_ZERO, Q12_NEG_ONE};
  localparam unit_vec_t UNIT_PPP  = '{Q12_ONE, Q12_ONE, Q12_ONE};
  localparam unit_vec_t UNIT_NNN  = '{Q12_NEG_ONE, Q12_NEG_ONE, Q12_NEG_ONE};
  localparam unit_vec_t UNIT_PN0  = '{Q12_ONE, Q12_NEG_ONE, Q12_ZERO};
  localparam unit_vec_t UNIT_NONE = '{Q12_ZERO, Q12_ZERO, Q12_ZERO};

  localparam int N_DIRECTED = 22;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // The zero vector maps to the positive x axis.
    '{31'sd0,  31'sd0,  31'sd0,  1'b1, UNIT_PX},
    // Single unit steps: both signs on x, plus on y, minus on z.
    '{31'sd1,  31'sd0,  31'sd0,  1'b1, UNIT_PX},
    '{-31'sd1, 31'sd0,  31'sd0,  1'b1, UNIT_NX},
    '{31'sd0,  31'sd1,  31'sd0,  1'b1, UNIT_PY},
    '{31'sd0,  31'sd0,  -31'sd1, 1'b1, UNIT_NZ},
    // Extreme components alone on one axis.
    '{V_MAX,   31'sd0,  31'sd0,  1'b1, UNIT_PX},
    '{V_MIN,   31'sd0,  31'sd0,  1'b1, UNIT_NX},
    '{31'sd0,  V_MIN,   31'sd0,  1'b1, UNIT_NY},
    '{31'sd0,  31'sd0,  V_MAX,   1'b1, UNIT_PZ},
    // Floor root of 3 and of 2 is one, so each non-zero component is +-1.
    '{31'sd1,  31'sd1,  31'sd1,  1'b1, UNIT_PPP},
    '{-31'sd1, -31'sd1, -31'sd1, 1'b1, UNIT_NNN},
    '{31'sd1,  -31'sd1, 31'sd0,  1'b1, UNIT_PN0},
    // Largest sums of squares and mixed signs.
    '{V_MAX,   V_MAX,   V_MAX,   1'b0, UNIT_NONE},
    '{V_MIN,   V_MIN,   V_MIN,   1'b0, UNIT_NONE},
    '{V_MIN,   V_MAX,   V_MIN,   1'b0, UNIT_NONE},
    '{V_MAX,   V_MIN,   31'sd0,  1'b0, UNIT_NONE},
    // Short vectors with exact and inexact lengths.
    '{31'sd3,  31'sd4,  31'sd0,  1'b0, UNIT_NONE},
    '{-31'sd3, 31'sd4,  31'sd12, 1'b0, UNIT_NONE},
    '{31'sd2,  31'sd1,  31'sd0,  1'b0, UNIT_NONE},
    // A tiny component beside an extreme one, and vice versa.
    '{31'sd1,  V_MAX,   31'sd0,  1'b0, UNIT_NONE},
    '{V_MIN,   31'sd1,  -31'sd1, 1'b0, UNIT_NONE},
    // Zero again straight after non-zero work.
    '{31'sd0,  31'sd0,  31'sd0,  1'b1, UNIT_PX}
  };

  logic clk;
  logic rst_n;

  q12vn_in_if  in_ch ();
  q12vn_out_if out_ch ();

  q12_vector_normalize_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // Expected unit vectors, oldest first.
  unit_vec_t   expected_units [$];
  int unsigned error_count;
  int unsigned results_checked;
  int unsigned zero_vectors_sent;
  int unsigned idle_cycles;
  int unsigned stall_left;
  // While calm is set neither side idles, so the unit runs back to back.
  bit          calm;

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bit-exact expected result for one vector: the floor root of the sum of
  // squares is found digit by digit, then each magnitude times 4096 is
  // divided by it and the sign restored, truncating toward zero.
  function automatic unit_vec_t normalise_q12(logic signed [IN_W-1:0] vx,
                                              logic signed [IN_W-1:0] vy,
                                              logic signed [IN_W-1:0] vz);
    logic signed [IN_W-1:0] comp [3];
    longint                 sext;
    longint unsigned        mag [3];
    bit                     neg [3];
    longint unsigned        sumsq;
    longint unsigned        rem;
    longint unsigned        root;
    longint unsigned        bitv;
    longint unsigned        quo;
    logic [63:0]            signed_quo;
    logic signed [OUT_W-1:0] res [3];
    unit_vec_t              u;
    comp[0] = vx;
    comp[1] = vy;
    comp[2] = vz;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      sext = longint'(comp[i]);
      neg[i] = (sext < 0);
      mag[i] = neg[i] ? longint'(-sext) : longint'(sext);
      sumsq += mag[i] * mag[i];
    end
    if (sumsq == 0) begin
      u = UNIT_PX;
      return u;
    end
    rem = sumsq;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > sumsq) begin
      bitv >>= 2;
    end
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    for (int i = 0; i < 3; i++) begin
      quo = (mag[i] << 12) / root;
      signed_quo = neg[i] ? (64'd0 - quo) : quo;
      res[i] = signed_quo[OUT_W-1:0];
    end
    u.x = res[0];
    u.y = res[1];
    u.z = res[2];
    return u;
  endfunction

  // Gap length for either side: mostly none, often a few cycles, now and
  // then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(40, 200);
  endfunction

  // A random component with the given number of magnitude bits and a random
  // sign; a width of IN_W or more gives any 31-bit pattern.
  function automatic logic signed [IN_W-1:0] rand_comp(int unsigned mag_bits);
    logic [IN_W-1:0] raw;
    logic [IN_W-1:0] mask;
    logic [IN_W-1:0] m;
    raw = IN_W'($urandom());
    if (mag_bits >= IN_W) begin
      return raw;
    end
    mask = (IN_W'(1) << mag_bits) - IN_W'(1);
    m = raw & mask;
    if ($urandom_range(0, 1) == 1) begin
      return -$signed(m);
    end
    return m;
  endfunction

  // Offers one vector after an optional gap and waits for its transfer.
  // Valid stays high on return so that a back-to-back vector can follow in
  // the same step; a next call with a gap, or the end of stimulus, lowers it.
  task automatic send_vector(logic signed [IN_W-1:0] vx,
                             logic signed [IN_W-1:0] vy,
                             logic signed [IN_W-1:0] vz,
                             bit typed, unit_vec_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.vec_x <= vx;
    in_ch.vec_y <= vy;
    in_ch.vec_z <= vz;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    expected_units.push_back(typed ? want : normalise_q12(vx, vy, vz));
    if (vx == 0 && vy == 0 && vz == 0) begin
      zero_vectors_sent++;
    end
  endtask

  // Result side: random stalls of random length, none begun while calm.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Every result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_units.size() == 0) begin
        $display("%0t: result (%0d, %0d, %0d) with no vector outstanding",
                 $time, out_ch.unit_x, out_ch.unit_y, out_ch.unit_z);
        error_count++;
      end else begin
        if (out_ch.unit_x !== expected_units[0].x || out_ch.unit_y !== expected_units[0].y ||
            out_ch.unit_z !== expected_units[0].z) begin
          $display("%0t: mismatch, expected (%0d, %0d, %0d), got (%0d, %0d, %0d)", $time,
                   expected_units[0].x, expected_units[0].y, expected_units[0].z,
                   out_ch.unit_x, out_ch.unit_y, out_ch.unit_z);
          error_count++;
        end
        void'(expected_units.pop_front());
        results_checked++;
      end
    end
  end

  // Watchdog: ends the run if neither side completes a transfer for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, expected_units.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic signed [IN_W-1:0] v [3];
    logic signed [IN_W-1:0] picks [5];
    int unsigned            kind;
    int unsigned            width;
    int unsigned            axis;

    error_count = 0;
    results_checked = 0;
    zero_vectors_sent = 0;
    idle_cycles = 0;
    stall_left = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.vec_x = '0;
    in_ch.vec_y = '0;
    in_ch.vec_z = '0;
    out_ch.ready = 1'b0;
    picks[0] = V_MIN;
    picks[1] = V_MAX;
    picks[2] = 31'sd0;
    picks[3] = 31'sd1;
    picks[4] = -31'sd1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_vector(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].z,
                  DIRECTED[r].typed, DIRECTED[r].want);
    end

    // Random vectors. Every fourth block of a hundred runs with no idling on
    // either side; the rest see gaps and stalls.
    for (int n = 0; n < N_RANDOM; n++) begin
      calm = ((n / 100) % 4 == 1);
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        for (int i = 0; i < 3; i++) v[i] = rand_comp(IN_W);
      end else if (kind < 55) begin
        // All three components of a similar size.
        width = $urandom_range(0, IN_W - 1);
        for (int i = 0; i < 3; i++) v[i] = rand_comp(width);
      end else if (kind < 70) begin
        for (int i = 0; i < 3; i++) v[i] = rand_comp($urandom_range(0, IN_W));
      end else if (kind < 80) begin
        // One dominant axis, so the result sits close to plus or minus one.
        axis = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
          v[i] = (i == axis) ? rand_comp(IN_W) : rand_comp($urandom_range(0, 4));
        end
      end else if (kind < 88) begin
        // Short vectors, where the floor root truncates hardest.
        for (int i = 0; i < 3; i++) v[i] = rand_comp($urandom_range(0, 3));
      end else if (kind < 93) begin
        for (int i = 0; i < 3; i++) v[i] = '0;
      end else begin
        for (int i = 0; i < 3; i++) v[i] = picks[$urandom_range(0, 4)];
      end
      send_vector(v[0], v[1], v[2], 1'b0, UNIT_NONE);
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    // Drain: the watchdog covers a result that never arrives.
    while (expected_units.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d directed and %0d random vectors, %0d of them zero vectors.",
             N_DIRECTED, N_RANDOM, zero_vectors_sent);
    $display("Checked %0d results under random gaps and stalls; %0d errors.",
             results_checked, error_count);
    if (error_count == 0 && expected_units.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
